// ===== hw/rtl/tlru_pkg.sv =====
// ----------------------------------------------------------------------------
// tlru_pkg
// Shared types and constants of the two-way LRU tag store and its counters.
// ----------------------------------------------------------------------------
package tlru_pkg;

    localparam int MAX_SET_BITS_DEF = 10;
    localparam int WAY_COUNT        = 2;
    localparam int TAG_W            = 64;
    localparam int ADDR_W           = 64;
    localparam int CNT_W            = 32;
    localparam int CFG_W            = 4;
    localparam int FUNC_W           = 2;

    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

    localparam logic CFG_OFFSET_BITS = 1'b0;
    localparam logic CFG_SET_BITS    = 1'b1;

    localparam logic [CFG_W-1:0] OFFSET_BITS_RESET = 4'd6;
    localparam logic [CFG_W-1:0] SET_BITS_RESET    = 4'd8;

    // per-set state word: LRU (next victim) bit and one valid bit per way
    typedef struct packed {
        logic                 lru;
        logic [WAY_COUNT-1:0] valid;
    } set_state_t;

    typedef logic [WAY_COUNT-1:0][TAG_W-1:0] tag_row_t;

    typedef struct packed {
        logic [CNT_W-1:0] read_acc;
        logic [CNT_W-1:0] read_miss;
        logic [CNT_W-1:0] write_acc;
        logic [CNT_W-1:0] write_miss;
    } counts_t;

    typedef struct packed {
        logic              en;
        logic [FUNC_W-1:0] func;
        logic              miss;
    } stat_upd_t;

endpackage

// ===== hw/rtl/tlru_ram.sv =====
// ----------------------------------------------------------------------------
// tlru_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tlru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/tlru_addr_split.sv =====
// ----------------------------------------------------------------------------
// tlru_addr_split
// Splits a byte address into set index and tag from the configured offset
// and set bit counts.
// ----------------------------------------------------------------------------
module tlru_addr_split
    import tlru_pkg::*;
#(
    parameter int MAX_SET_BITS = MAX_SET_BITS_DEF
) (
    input  logic [ADDR_W-1:0]                                   address,
    input  logic [CFG_W-1:0]                                    offset_bits,
    input  logic [CFG_W-1:0]                                    set_bits,
    output logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0]  index,
    output logic [TAG_W-1:0]                                    tag
);

    localparam int IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

    logic [4:0]        sb;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] idx_full;

    // saturate the set bit count at the built maximum
    assign sb       = (5'(set_bits) > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS) : 5'(set_bits);
    assign mask     = (ADDR_W'(1) << sb) - ADDR_W'(1);
    assign idx_full = (address >> offset_bits) & mask;
    assign index    = idx_full[IDX_W-1:0];
    assign tag      = TAG_W'(address >> (6'(offset_bits) + 6'(sb)));

endmodule

// ===== hw/rtl/tlru_stats.sv =====
// ----------------------------------------------------------------------------
// tlru_stats
// Wrapping access and miss counters, with clear.
// ----------------------------------------------------------------------------
module tlru_stats
    import tlru_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  stat_upd_t upd,
    output counts_t   counts_next
);

    counts_t counts_reg;

    always_comb
    begin
        counts_next = counts_reg;
        if (upd.en)
        begin
            unique case (upd.func)
                FUNC_READ:
                begin
                    counts_next.read_acc = counts_reg.read_acc + CNT_W'(1);
                    if (upd.miss)
                    begin
                        counts_next.read_miss = counts_reg.read_miss + CNT_W'(1);
                    end
                end
                FUNC_WRITE:
                begin
                    counts_next.write_acc = counts_reg.write_acc + CNT_W'(1);
                    if (upd.miss)
                    begin
                        counts_next.write_miss = counts_reg.write_miss + CNT_W'(1);
                    end
                end
                FUNC_FLUSH:
                begin
                    counts_next = counts_reg;
                end
                FUNC_CLEAR:
                begin
                    counts_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counts_reg <= '0;
        end
        else
        begin
            counts_reg <= counts_next;
        end
    end

endmodule

// ===== hw/rtl/two_way_lru_cache_hit_counter_unit.sv =====
// ----------------------------------------------------------------------------
// two_way_lru_cache_hit_counter_unit
// Two-way set-associative tag store with per-set LRU and access counters.
// Access: a read or write item reads the tag and set-state RAMs on acceptance;
//   one item is in work at a time, and no new item is taken until the result
//   is registered and the read-then-write-back of the tag and set-state RAMs is done.
// Flush: sweeps every set of the set-state RAM, then gives the result.
// Reset: a clearing pass over every set; in_stall stays high.
// ----------------------------------------------------------------------------
module two_way_lru_cache_hit_counter_unit
    import tlru_pkg::*;
#(
    parameter int MAX_SET_BITS = MAX_SET_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [FUNC_W-1:0] func,
    input  logic [ADDR_W-1:0] address,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              hit,
    output logic [CNT_W-1:0]  read_accesses,
    output logic [CNT_W-1:0]  read_misses,
    output logic [CNT_W-1:0]  write_accesses,
    output logic [CNT_W-1:0]  write_misses
);

    localparam int SET_DEPTH = 1 << MAX_SET_BITS;
    localparam int IDX_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam logic [IDX_W-1:0] LAST_SET = IDX_W'(SET_DEPTH - 1);

    localparam logic [1:0] ST_SWEEP = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  sweep_cnt_reg, sweep_cnt_next;
    logic              flush_pend_reg, flush_pend_next;
    logic [CFG_W-1:0]  offset_bits_reg, set_bits_reg;

    logic [FUNC_W-1:0] func_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic              out_valid_reg, out_valid_next;
    logic              hit_reg;
    counts_t           counts_out_reg;

    logic [IDX_W-1:0]  split_index;
    logic [TAG_W-1:0]  split_tag;

    logic              accept, out_free, emit, is_access, in_is_access;
    logic              hit0, hit1, lookup_hit, victim;

    set_state_t        st_rd, st_wr;
    tag_row_t          tags_rd, tags_wr;
    logic              st_we, tag_we, rd_en;
    logic [IDX_W-1:0]  st_waddr;

    stat_upd_t         upd;
    counts_t           counts_next;

    assign in_stall     = (state_reg != ST_IDLE);
    assign accept       = in_valid && !in_stall;
    assign out_free     = !out_valid_reg || !out_stall;
    assign emit         = (state_reg == ST_DONE) && out_free;
    assign is_access    = (func_reg == FUNC_READ) || (func_reg == FUNC_WRITE);
    assign in_is_access = (func == FUNC_READ) || (func == FUNC_WRITE);
    assign rd_en        = accept && in_is_access;

    tlru_addr_split #(
        .MAX_SET_BITS (MAX_SET_BITS)
    ) u_split (
        .address     (address),
        .offset_bits (offset_bits_reg),
        .set_bits    (set_bits_reg),
        .index       (split_index),
        .tag         (split_tag)
    );

    tlru_ram #(
        .WIDTH ($bits(set_state_t)),
        .DEPTH (SET_DEPTH)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (st_wr),
        .rd_en   (rd_en),
        .rd_addr (split_index),
        .rd_data (st_rd)
    );

    tlru_ram #(
        .WIDTH ($bits(tag_row_t)),
        .DEPTH (SET_DEPTH)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (tag_we),
        .wr_addr (idx_reg),
        .wr_data (tags_wr),
        .rd_en   (rd_en),
        .rd_addr (split_index),
        .rd_data (tags_rd)
    );

    tlru_stats u_stats (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd         (upd),
        .counts_next (counts_next)
    );

    // hit check; way 0 wins when both ways match
    assign hit0       = st_rd.valid[0] && (tags_rd[0] == tag_reg);
    assign hit1       = st_rd.valid[1] && (tags_rd[1] == tag_reg);
    assign lookup_hit = hit0 || hit1;
    assign victim     = st_rd.lru;

    always_comb
    begin
        tags_wr         = tags_rd;
        tags_wr[victim] = tag_reg;
        st_wr           = st_rd;
        if (lookup_hit)
        begin
            st_wr.lru = hit0;
        end
        else
        begin
            st_wr.valid[victim] = 1'b1;
            st_wr.lru           = !victim;
        end
        st_we    = 1'b0;
        st_waddr = idx_reg;
        tag_we   = 1'b0;
        if (state_reg == ST_SWEEP)
        begin
            st_we    = 1'b1;
            st_waddr = sweep_cnt_reg;
            st_wr    = '0;
        end
        else if (emit && is_access)
        begin
            st_we  = 1'b1;
            tag_we = !lookup_hit;
        end
    end

    assign upd.en   = emit;
    assign upd.func = func_reg;
    assign upd.miss = !lookup_hit;

    always_comb
    begin
        state_next      = state_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        flush_pend_next = flush_pend_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                sweep_cnt_next = sweep_cnt_reg + IDX_W'(1);
                if (sweep_cnt_reg == LAST_SET)
                begin
                    sweep_cnt_next = '0;
                    state_next     = flush_pend_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_FLUSH)
                    begin
                        state_next      = ST_SWEEP;
                        flush_pend_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next      = ST_IDLE;
                    flush_pend_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // hold a waiting result until taken
    assign out_valid_next = emit ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_SWEEP;
            sweep_cnt_reg   <= '0;
            flush_pend_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            offset_bits_reg <= OFFSET_BITS_RESET;
            set_bits_reg    <= SET_BITS_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            flush_pend_reg <= flush_pend_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    CFG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                    CFG_SET_BITS:    set_bits_reg    <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            tag_reg  <= split_tag;
            idx_reg  <= split_index;
        end
        if (emit)
        begin
            hit_reg        <= is_access && lookup_hit;
            counts_out_reg <= counts_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign hit            = hit_reg;
    assign read_accesses  = counts_out_reg.read_acc;
    assign read_misses    = counts_out_reg.read_miss;
    assign write_accesses = counts_out_reg.write_acc;
    assign write_misses   = counts_out_reg.write_miss;

endmodule

// ===== hw/rtl/tlru_checker.sv =====
// ----------------------------------------------------------------------------
// tlru_checker
// Port-level checks of the tag store's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module tlru_checker
    import tlru_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic              hit,
    input logic [CNT_W-1:0]  read_accesses,
    input logic [CNT_W-1:0]  read_misses,
    input logic [CNT_W-1:0]  write_accesses,
    input logic [CNT_W-1:0]  write_misses
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(read_misses))
    else $error("stalled result changed or dropped");

    // one item in work: the block stalls right after taking one
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

    // a new result only comes out of a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no item in work");

    // a stalled result keeps the rest of its counters
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(read_accesses) && $stable(write_accesses)
            && $stable(write_misses))
    else $error("stalled counters changed");

endmodule

bind two_way_lru_cache_hit_counter_unit tlru_checker u_tlru_checker (.*);

// ===== test/cache_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cache_scoreboard_pkg
// Tag store tracker for the two-way LRU cache: mirrors tags, valid and LRU
// bits and the four access counters, and checks each result in order.
// ----------------------------------------------------------------------------
package cache_scoreboard_pkg;

    import tlru_pkg::*;

    localparam int SET_DEPTH = 1 << MAX_SET_BITS_DEF;

    typedef struct {
        logic    hit;
        counts_t counts;
    } lookup_outcome_t;

    class cache_scoreboard;

        bit [TAG_W-1:0]  tag_mem [SET_DEPTH][WAY_COUNT];
        bit              line_valid [SET_DEPTH][WAY_COUNT];
        bit              victim_way [SET_DEPTH];
        counts_t         counts;
        int              offset_bits;
        int              set_bits;
        lookup_outcome_t predicted_outcomes [$];
        int              errors;
        int              results_seen;
        int              accesses;
        int              hits;
        int              flushes;
        int              clears;

        function new();
            foreach (line_valid[i, j]) line_valid[i][j] = 1'b0;
            foreach (victim_way[i]) victim_way[i] = 1'b0;
            counts       = '0;
            offset_bits  = int'(OFFSET_BITS_RESET);
            set_bits     = int'(SET_BITS_RESET);
            errors       = 0;
            results_seen = 0;
            accesses     = 0;
            hits         = 0;
            flushes      = 0;
            clears       = 0;
        endfunction

        function void set_config(logic idx, logic [CFG_W-1:0] value);
            if (idx == CFG_OFFSET_BITS)
                offset_bits = int'(value);
            else
                set_bits = int'(value);
        endfunction

        function int used_set_bits();
            return (set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : set_bits;
        endfunction

        // Look up one address, fill the LRU way on a miss, update LRU.
        function bit lookup_line(logic [ADDR_W-1:0] addr);
            int             sb;
            int             idx;
            bit [TAG_W-1:0] tag_val;
            bit [63:0]      mask;
            int             w;
            sb      = used_set_bits();
            mask    = (64'd1 << sb) - 64'd1;
            idx     = int'((addr >> offset_bits) & mask);
            tag_val = addr >> (offset_bits + sb);
            for (w = 0; w < WAY_COUNT; w++)
            begin
                if (line_valid[idx][w] && tag_mem[idx][w] == tag_val)
                begin
                    victim_way[idx] = (w == 0);
                    return 1'b1;
                end
            end
            w = victim_way[idx];
            tag_mem[idx][w]    = tag_val;
            line_valid[idx][w] = 1'b1;
            victim_way[idx]    = (w == 0);
            return 1'b0;
        endfunction

        function void note_input(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] addr);
            lookup_outcome_t outc;
            outc.hit = 1'b0;
            case (f)
                FUNC_READ:
                begin
                    outc.hit = lookup_line(addr);
                    counts.read_acc++;
                    if (!outc.hit) counts.read_miss++;
                end
                FUNC_WRITE:
                begin
                    outc.hit = lookup_line(addr);
                    counts.write_acc++;
                    if (!outc.hit) counts.write_miss++;
                end
                FUNC_FLUSH:
                begin
                    // every built set, not only those in use
                    foreach (line_valid[i, j]) line_valid[i][j] = 1'b0;
                    foreach (victim_way[i]) victim_way[i] = 1'b0;
                    flushes++;
                end
                default:
                begin
                    counts = '0;
                    clears++;
                end
            endcase
            if (f == FUNC_READ || f == FUNC_WRITE)
            begin
                accesses++;
                if (outc.hit) hits++;
            end
            outc.counts = counts;
            predicted_outcomes.push_back(outc);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch at result %0d: %s got %0h expected %0h",
                     results_seen, what, got, want);
            errors++;
        endtask

        task check_result(logic got_hit, counts_t got);
            lookup_outcome_t want;
            results_seen++;
            if (predicted_outcomes.size() == 0)
            begin
                report_mismatch("unexpected result, hit", got_hit, 0);
                return;
            end
            want = predicted_outcomes.pop_front();
            if (got_hit !== want.hit)
                report_mismatch("hit", got_hit, want.hit);
            if (got.read_acc !== want.counts.read_acc)
                report_mismatch("read_accesses", got.read_acc, want.counts.read_acc);
            if (got.read_miss !== want.counts.read_miss)
                report_mismatch("read_misses", got.read_miss, want.counts.read_miss);
            if (got.write_acc !== want.counts.write_acc)
                report_mismatch("write_accesses", got.write_acc, want.counts.write_acc);
            if (got.write_miss !== want.counts.write_miss)
                report_mismatch("write_misses", got.write_miss, want.counts.write_miss);
        endtask

        function int pending();
            return predicted_outcomes.size();
        endfunction

    endclass

endpackage

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for the two-way LRU tag store: directed hit, miss, eviction,
// flush and clear items, then random items over many register settings
// with random idling on both channels in the earlier segments, checked against a tracker.
// ----------------------------------------------------------------------------
module tb;

    import tlru_pkg::*;
    import cache_scoreboard_pkg::*;

    localparam int SEGMENTS     = 8;
    localparam int SEGMENT_ITEMS = 200;

    logic              clk;
    logic              rst_n;
    logic              cfg_write_en;
    logic              cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] address;
    logic              out_valid;
    logic              out_stall;
    logic              hit;
    logic [CNT_W-1:0]  read_accesses;
    logic [CNT_W-1:0]  read_misses;
    logic [CNT_W-1:0]  write_accesses;
    logic [CNT_W-1:0]  write_misses;

    int in_idle_pct;
    int out_idle_pct;
    int settings_used;

    int seg_offset [SEGMENTS] = '{0, 12, 15, 3, 6, 1, 12, 0};
    int seg_sets   [SEGMENTS] = '{0, 10, 15, 2, 8, 4, 0, 10};

    cache_scoreboard tracker;

    two_way_lru_cache_hit_counter_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .address        (address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .read_accesses  (read_accesses),
        .read_misses    (read_misses),
        .write_accesses (write_accesses),
        .write_misses   (write_misses)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("timeout with %0d results outstanding", tracker.pending());
        $display("two_way_lru_cache_hit_counter_unit regression: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    always @(posedge clk)
    begin
        counts_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.note_input(func, address);
            if (out_valid && !out_stall)
            begin
                got.read_acc   = read_accesses;
                got.read_miss  = read_misses;
                got.write_acc  = write_accesses;
                got.write_miss = write_misses;
                tracker.check_result(hit, got);
            end
        end
    end

    // Hold the item until accepted; valid stays high on return.
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        address  <= a;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Drop valid and wait for every predicted result.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Leave the write enable high; the caller drops it after its last write.
    task automatic write_cfg(input logic idx, input logic [CFG_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        tracker.set_config(idx, value);
    endtask

    task automatic apply_setting(input int ob, input int sb);
        drain();
        write_cfg(CFG_OFFSET_BITS, CFG_W'(ob));
        write_cfg(CFG_SET_BITS, CFG_W'(sb));
        cfg_write_en <= 1'b0;
        settings_used++;
    endtask

    task automatic run_directed();
        logic [ADDR_W-1:0] ones;
        ones = '1;
        // reset setting: 6 offset bits, 8 set bits, so 0x4000 is tag 1 of set 0
        send_item(FUNC_READ, 64'h0);
        send_item(FUNC_READ, 64'h3f);
        send_item(FUNC_WRITE, ones);
        send_item(FUNC_WRITE, ones);
        send_item(FUNC_WRITE, 64'h4000);
        send_item(FUNC_READ, 64'h4000);
        send_item(FUNC_READ, 64'h0);
        // evict the LRU way, then miss on it
        send_item(FUNC_WRITE, 64'h8000);
        send_item(FUNC_READ, 64'h4000);
        send_item(FUNC_CLEAR, 64'h1234_5678_9abc_def0);
        send_item(FUNC_READ, 64'h8000);
        send_item(FUNC_FLUSH, ones);
        send_item(FUNC_READ, 64'h8000);
        send_item(FUNC_WRITE, 64'h8000);
        // set bits above the built maximum saturate; offset above twelve is kept
        apply_setting(13, 15);
        send_item(FUNC_WRITE, 64'h0000_0000_07ff_e000);
        send_item(FUNC_READ, 64'h0000_0000_07ff_ffff);
        send_item(FUNC_READ, ones);
        // flush must clear sets outside the ones in use
        apply_setting(0, 10);
        send_item(FUNC_WRITE, 64'd1023);
        apply_setting(0, 2);
        send_item(FUNC_FLUSH, 64'h0);
        apply_setting(0, 10);
        send_item(FUNC_READ, 64'd1023);
        send_item(FUNC_CLEAR, ones);
        drain();
    endtask

    task automatic run_segment(input int n, input bit with_pause);
        logic [ADDR_W-1:0] tag_pool [4];
        int                set_pool [3];
        int                ob;
        int                sb;
        int                k;
        int                r;
        logic [FUNC_W-1:0] f;
        logic [ADDR_W-1:0] a;
        ob = tracker.offset_bits;
        sb = tracker.used_set_bits();
        tag_pool[0] = 64'd0;
        tag_pool[1] = 64'd1;
        tag_pool[2] = 64'($urandom);
        tag_pool[3] = {$urandom, $urandom};
        set_pool[0] = 0;
        set_pool[1] = (1 << sb) - 1;
        set_pool[2] = $urandom_range((1 << sb) - 1);
        for (k = 0; k < n; k++)
        begin
            if (with_pause && k == n / 2)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (tracker.pending() != 0) @(posedge clk);
            end
            r = $urandom_range(99);
            if (r < 46)
                f = FUNC_READ;
            else if (r < 92)
                f = FUNC_WRITE;
            else if (r < 94)
                f = FUNC_FLUSH;
            else
                f = FUNC_CLEAR;
            if ($urandom_range(99) < 85)
                a = (tag_pool[$urandom_range(3)] << (ob + sb))
                  | (64'(set_pool[$urandom_range(2)]) << ob)
                  | (64'($urandom) & ((64'd1 << ob) - 64'd1));
            else
                a = {$urandom, $urandom};
            send_item(f, a);
        end
    endtask

    initial
    begin
        int s;
        tracker       = new();
        settings_used = 1;
        rst_n         = 1'b0;
        cfg_write_en  = 1'b0;
        cfg_index     = CFG_OFFSET_BITS;
        cfg_data      = '0;
        in_valid      = 1'b0;
        func          = FUNC_READ;
        address       = '0;
        out_stall     = 1'b0;
        in_idle_pct   = 35;
        out_idle_pct  = 68;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // wait out the clearing pass
        while (in_stall) @(posedge clk);

        run_directed();

        for (s = 0; s < SEGMENTS; s++)
        begin
            if (s == 3)
            begin
                in_idle_pct  = 68;
                out_idle_pct = 35;
            end
            else if (s == 6)
            begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            apply_setting(seg_offset[s], seg_sets[s]);
            run_segment(SEGMENT_ITEMS, s == 4);
        end

        drain();
        repeat (20) @(posedge clk);
        $display("covered %0d results: %0d accesses with %0d hits, %0d flushes, %0d clears",
                 tracker.results_seen, tracker.accesses, tracker.hits,
                 tracker.flushes, tracker.clears);
        $display("over %0d register settings, %0d mismatches",
                 settings_used, tracker.errors);
        if (tracker.errors == 0)
            $display("two_way_lru_cache_hit_counter_unit regression: pass");
        else
            $display("two_way_lru_cache_hit_counter_unit regression: fail");
        $finish;
    end

endmodule
